### rtl/file_header_validator_defines.svh
// Assertion macros for the header validator
`ifndef FILE_HEADER_VALIDATOR_DEFINES_SVH
`define FILE_HEADER_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FHV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fhv_pkg.sv
// Package: header layout constants, character codes and shared types
`default_nettype none

package fhv_pkg;

    localparam logic [6:0] POS_MAGIC_END  = 7'd7;
    localparam logic [6:0] POS_VEND_START = 7'd8;
    localparam logic [6:0] POS_SEP        = 7'd32;
    localparam logic [6:0] POS_USER_START = 7'd34;
    localparam logic [6:0] POS_TAIL_START = 7'd96;
    localparam logic [6:0] POS_LAST       = 7'd127;

    localparam logic [4:0] VEND_LAST_OFF  = 5'd23;
    localparam logic [5:0] USER_LAST_OFF  = 6'd61;
    localparam logic [4:0] TAIL_NL2_OFF   = 5'd30;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_F     = 8'h46;

    typedef struct packed {
        logic       all_pass;
        logic       vend_space;
        logic       user_space;
        logic [5:0] user_last;
    } t_fhv_state;

    typedef struct packed {
        logic       in_user;
        logic [5:0] user_index;
        logic       done;
        logic       ok;
        logic [5:0] user_length;
    } t_fhv_res;

    localparam t_fhv_state FHV_STATE_RESET = '{
        all_pass:   1'b1,
        vend_space: 1'b0,
        user_space: 1'b0,
        user_last:  6'd0
    };

    // magic string "scdata0"
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h63;
            3'd2:    c = 8'h64;
            3'd3:    c = 8'h61;
            3'd4:    c = 8'h74;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/file_header_validator.sv
// Top level: streaming 128-byte file header validator
// An accepted byte passes through the input register and then the result register to the result ports.
// Throughput: one byte per cycle, sustained; the only limit is output backpressure.
// Input register -> check logic -> result register; ready passes back combinationally.
// Reset (i_rst_n low, synchronous): both stages empty, position 0, pass flag set.
// Payload registers are not reset.
`default_nettype none

module file_header_validator import fhv_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input byte channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_header_byte,
    // result channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_echo_byte,
    output logic            o_in_user_field,
    output logic [5:0]      o_user_index,
    output logic            o_header_done,
    output logic            o_header_ok,
    output logic [5:0]      o_user_length
);

`include "file_header_validator_defines.svh"

    // stage 1: input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    // stage 2: result register
    logic       r_s2_valid;
    logic [7:0] r_s2_byte;
    t_fhv_res   r_s2_res;

    // running header state, advanced once per byte moving into stage 2
    logic [6:0] r_pos;
    t_fhv_state r_state;

    logic       s2_load;
    logic       s1_adv;
    logic       in_take;

    logic [6:0] n_pos;
    t_fhv_state n_state;
    t_fhv_res   chk_res;

    // stage 2 frees up when empty or when its transaction is taken this cycle
    assign s2_load = !r_s2_valid || i_ready;
    assign s1_adv  = r_s1_valid && s2_load;
    assign o_ready = !r_s1_valid || s2_load;
    assign in_take = i_valid && o_ready;

    fhv_check u_check (
        .i_pos       (r_pos),
        .i_byte      (r_s1_byte),
        .i_state     (r_state),
        .o_state_nxt (n_state),
        .o_pos_nxt   (n_pos),
        .o_res       (chk_res)
    );

    // control: valid bits, position and running checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pos      <= 7'd0;
            r_state    <= FHV_STATE_RESET;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_pos   <= n_pos;
                r_state <= n_state;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_header_byte;
        end
        if (s1_adv) begin
            r_s2_byte <= r_s1_byte;
            r_s2_res  <= chk_res;
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_echo_byte     = r_s2_byte;
    assign o_in_user_field = r_s2_res.in_user;
    assign o_user_index    = r_s2_res.user_index;
    assign o_header_done   = r_s2_res.done;
    assign o_header_ok     = r_s2_res.ok;
    assign o_user_length   = r_s2_res.user_length;

    // a pass is only reported on the closing byte
    `FHV_ASSERT_NOW(a_ok_only_on_done, i_clk, i_rst_n,
        o_valid && o_header_ok, o_header_done, "header_ok without header_done")
    // a nonzero length only comes with a pass
    `FHV_ASSERT_NOW(a_len_needs_ok, i_clk, i_rst_n,
        o_valid && (o_user_length != 6'd0), o_header_ok,
        "user_length set on a failed or open header")
    // offsets outside the user field read as zero
    `FHV_ASSERT_NOW(a_index_outside_user, i_clk, i_rst_n,
        o_valid && !o_in_user_field, o_user_index == 6'd0,
        "user_index nonzero outside user field")
    // the closing byte wraps the position and restores the pass flag
    `FHV_ASSERT_NEXT(a_wrap_after_done, i_clk, i_rst_n,
        s1_adv && chk_res.done, (r_pos == 7'd0) && r_state.all_pass,
        "state not restored after header end")

endmodule

`default_nettype wire

### rtl/fhv_check.sv
// Per-byte layout check and running-state update
`default_nettype none

module fhv_check import fhv_pkg::*; (
    input  wire logic [6:0] i_pos,
    input  wire logic [7:0] i_byte,
    input  wire t_fhv_state i_state,
    output t_fhv_state      o_state_nxt,
    output logic [6:0]      o_pos_nxt,
    output t_fhv_res        o_res
);

    logic       good;
    logic       is_sp;
    logic       is_dash;
    logic [6:0] vdiff;
    logic [6:0] udiff;
    logic [6:0] tdiff;
    logic [4:0] voff;
    logic [5:0] uoff;
    logic [4:0] toff;
    logic       done;
    t_fhv_state st;

    assign is_sp   = (i_byte == CH_SPACE);
    assign is_dash = (i_byte == CH_DASH);
    assign vdiff   = i_pos - POS_VEND_START;
    assign udiff   = i_pos - POS_USER_START;
    assign tdiff   = i_pos - POS_TAIL_START;
    assign voff    = vdiff[4:0];
    assign uoff    = udiff[5:0];
    assign toff    = tdiff[4:0];
    assign done    = (i_pos == POS_LAST);

    always_comb begin
        st              = i_state;
        good            = 1'b1;
        o_res.in_user   = 1'b0;
        o_res.user_index = 6'd0;
        if (i_pos < POS_MAGIC_END) begin
            good = (i_byte == magic_char(i_pos[2:0]));
        end else if (i_pos == POS_MAGIC_END) begin
            good = is_sp;
        end else if (i_pos < POS_SEP) begin
            // vendor field: only the pad structure is checked
            if (voff == 5'd0) begin
                st.vend_space = is_sp;
            end else if (voff < VEND_LAST_OFF) begin
                if (!is_dash) begin
                    st.vend_space = is_sp;
                end
            end else begin
                good = (i_byte == CH_NL) && i_state.vend_space;
            end
        end else if (i_pos == POS_SEP) begin
            good = (i_byte == CH_F);
        end else if (i_pos == POS_USER_START - 7'd1) begin
            good = is_sp;
        end else if (i_pos < POS_TAIL_START) begin
            o_res.in_user    = 1'b1;
            o_res.user_index = uoff;
            if (uoff == 6'd0) begin
                st.user_last  = 6'd0;
                st.user_space = is_sp;
            end else if (uoff < USER_LAST_OFF) begin
                if (!is_dash) begin
                    st.user_last  = uoff;
                    st.user_space = is_sp;
                end
            end else begin
                good = (i_byte == CH_NL) && i_state.user_space;
            end
        end else begin
            if (toff == 5'd0 || toff >= TAIL_NL2_OFF) begin
                good = (i_byte == CH_NL);
            end else begin
                good = (i_byte == CH_EQ);
            end
        end
        st.all_pass = i_state.all_pass & good;

        o_res.done        = done;
        o_res.ok          = done & st.all_pass;
        o_res.user_length = (done & st.all_pass) ? i_state.user_last : 6'd0;

        // header boundary: everything returns to reset
        if (done) begin
            o_state_nxt = FHV_STATE_RESET;
            o_pos_nxt   = 7'd0;
        end else begin
            o_state_nxt = st;
            o_pos_nxt   = i_pos + 7'd1;
        end
    end

endmodule

`default_nettype wire
